[rtl/rufsf_pkg.sv]
// Shared constants, control word type and microcode table for the union-find spanning forest core.
package rufsf_pkg;

   // Sizes of the node table and of the fields.
   localparam int NODES     = 4096;
   localparam int NODE_W    = $clog2(NODES);
   localparam int COUNT_W   = 12;
   localparam int NCOUNT_W  = 13;
   localparam int UPC_W     = 5;

   localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = NCOUNT_W'(NODES);
   localparam logic [NODE_W-1:0]   LAST_NODE        = NODE_W'(NODES - 1);

   // Datapath actions.
   localparam logic [3:0] ACT_NONE      = 4'd0;
   localparam logic [3:0] ACT_LATCH     = 4'd1;
   localparam logic [3:0] ACT_CLEAR     = 4'd2;
   localparam logic [3:0] ACT_RD_X      = 4'd3;
   localparam logic [3:0] ACT_LD_PX_RDY = 4'd4;
   localparam logic [3:0] ACT_LD_PY     = 4'd5;
   localparam logic [3:0] ACT_LD_PX     = 4'd6;
   localparam logic [3:0] ACT_STEP_X    = 4'd7;
   localparam logic [3:0] ACT_STEP_Y    = 4'd8;
   localparam logic [3:0] ACT_JOIN      = 4'd9;
   localparam logic [3:0] ACT_LINK_X    = 4'd10;
   localparam logic [3:0] ACT_LINK_Y    = 4'd11;
   localparam logic [3:0] ACT_LOAD_OUT  = 4'd12;

   // Jump conditions.
   localparam logic [3:0] CND_NEVER     = 4'd0;
   localparam logic [3:0] CND_ALWAYS    = 4'd1;
   localparam logic [3:0] CND_REQ_FIRE  = 4'd2;
   localparam logic [3:0] CND_NOT_FRESH = 4'd3;
   localparam logic [3:0] CND_CLR_LAST  = 4'd4;
   localparam logic [3:0] CND_OOR       = 4'd5;
   localparam logic [3:0] CND_EQ        = 4'd6;
   localparam logic [3:0] CND_LT        = 4'd7;
   localparam logic [3:0] CND_X_ROOT    = 4'd8;
   localparam logic [3:0] CND_Y_ROOT    = 4'd9;
   localparam logic [3:0] CND_OUT_FREE  = 4'd10;

   // Program steps.
   localparam logic [UPC_W-1:0] STEP_IDLE      = 5'd0;
   localparam logic [UPC_W-1:0] STEP_FRESH     = 5'd1;
   localparam logic [UPC_W-1:0] STEP_CLEAR     = 5'd2;
   localparam logic [UPC_W-1:0] STEP_RANGE     = 5'd3;
   localparam logic [UPC_W-1:0] STEP_LOAD_PX   = 5'd4;
   localparam logic [UPC_W-1:0] STEP_LOAD_PY   = 5'd5;
   localparam logic [UPC_W-1:0] STEP_CMP_EQ    = 5'd6;
   localparam logic [UPC_W-1:0] STEP_CMP_LT    = 5'd7;
   localparam logic [UPC_W-1:0] STEP_Y_ROOT    = 5'd8;
   localparam logic [UPC_W-1:0] STEP_Y_HOP     = 5'd9;
   localparam logic [UPC_W-1:0] STEP_Y_LOAD    = 5'd10;
   localparam logic [UPC_W-1:0] STEP_X_ROOT    = 5'd11;
   localparam logic [UPC_W-1:0] STEP_X_HOP     = 5'd12;
   localparam logic [UPC_W-1:0] STEP_X_LOAD    = 5'd13;
   localparam logic [UPC_W-1:0] STEP_JOIN      = 5'd14;
   localparam logic [UPC_W-1:0] STEP_LINK_Y    = 5'd15;
   localparam logic [UPC_W-1:0] STEP_LINK_X    = 5'd16;
   localparam logic [UPC_W-1:0] STEP_OUT       = 5'd17;
   localparam logic [UPC_W-1:0] STEP_RST_CLEAR = 5'd18;

   // One control word: the action, the jump condition, whether to hold the
   // step while the condition is false, and the jump target.
   typedef struct packed {
      logic [3:0]       act;
      logic [3:0]       cond;
      logic             hold;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type make_word(input logic [3:0] act,
                                               input logic [3:0] cond,
                                               input logic       hold,
                                               input logic [UPC_W-1:0] target);
      ctrl_word_type w;
      w.act    = act;
      w.cond   = cond;
      w.hold   = hold;
      w.target = target;
      return w;
   endfunction

   // The microprogram. A taken condition jumps to the target; otherwise the
   // step holds or falls through to the next one.
   function automatic ctrl_word_type ucode_rom(input logic [UPC_W-1:0] step);
      ctrl_word_type w;
      case (step)
         STEP_IDLE:      w = make_word(ACT_LATCH,     CND_REQ_FIRE,  1'b1, STEP_FRESH);
         STEP_FRESH:     w = make_word(ACT_NONE,      CND_NOT_FRESH, 1'b0, STEP_RANGE);
         STEP_CLEAR:     w = make_word(ACT_CLEAR,     CND_CLR_LAST,  1'b1, STEP_RANGE);
         STEP_RANGE:     w = make_word(ACT_RD_X,      CND_OOR,       1'b0, STEP_OUT);
         STEP_LOAD_PX:   w = make_word(ACT_LD_PX_RDY, CND_NEVER,     1'b0, STEP_IDLE);
         STEP_LOAD_PY:   w = make_word(ACT_LD_PY,     CND_NEVER,     1'b0, STEP_IDLE);
         STEP_CMP_EQ:    w = make_word(ACT_NONE,      CND_EQ,        1'b0, STEP_JOIN);
         STEP_CMP_LT:    w = make_word(ACT_NONE,      CND_LT,        1'b0, STEP_X_ROOT);
         STEP_Y_ROOT:    w = make_word(ACT_NONE,      CND_Y_ROOT,    1'b0, STEP_LINK_Y);
         STEP_Y_HOP:     w = make_word(ACT_STEP_Y,    CND_NEVER,     1'b0, STEP_IDLE);
         STEP_Y_LOAD:    w = make_word(ACT_LD_PY,     CND_ALWAYS,    1'b0, STEP_CMP_EQ);
         STEP_X_ROOT:    w = make_word(ACT_NONE,      CND_X_ROOT,    1'b0, STEP_LINK_X);
         STEP_X_HOP:     w = make_word(ACT_STEP_X,    CND_NEVER,     1'b0, STEP_IDLE);
         STEP_X_LOAD:    w = make_word(ACT_LD_PX,     CND_ALWAYS,    1'b0, STEP_CMP_EQ);
         STEP_JOIN:      w = make_word(ACT_JOIN,      CND_ALWAYS,    1'b0, STEP_OUT);
         STEP_LINK_Y:    w = make_word(ACT_LINK_Y,    CND_ALWAYS,    1'b0, STEP_OUT);
         STEP_LINK_X:    w = make_word(ACT_LINK_X,    CND_NEVER,     1'b0, STEP_IDLE);
         STEP_OUT:       w = make_word(ACT_LOAD_OUT,  CND_OUT_FREE,  1'b1, STEP_IDLE);
         STEP_RST_CLEAR: w = make_word(ACT_CLEAR,     CND_CLR_LAST,  1'b1, STEP_IDLE);
         default:        w = make_word(ACT_NONE,      CND_ALWAYS,    1'b0, STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

[rtl/rufsf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rufsf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rem_union_find_spanning_forest_core.sv]
// Top level: microcoded union-find engine that counts spanning-forest edges.
// An in-range edge climbs the parent chains, one hop at a time on the side with the smaller parent,
//    until the parents meet (the edge is redundant) or a root is linked (it merges two trees).
// An out-of-range edge skips the walk; new_graph adds a table clearing pass.
// Throughput: one transaction at a time; the next is accepted the cycle after the result is loaded.
// Reset (synchronous, active high) runs a clearing pass that writes the identity into
//    the parent table; req_tready stays low until it completes. node_count resets to 4096.
module rem_union_find_spanning_forest_core
   import rufsf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Edge input channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // [11:0] node_a, [23:12] node_b
   input  logic                req_tuser,   // [0] new_graph
   // Result channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // [0] already_joined, [12:1] tree_edge_count,
                                            // [13] out_of_range, [15:14] zero
   // Configuration register node_count.
   input  logic                csr_wr_en,
   input  logic [NCOUNT_W-1:0] csr_wr_data
);

   // The microprogram counter selects one control word per cycle from the
   // read-only table in the package. All datapath registers below are
   // updated by the action field of that word.
   logic [UPC_W-1:0]    upc_ff, upc_in;
   ctrl_word_type       cw;
   logic                cond_true;

   logic [NCOUNT_W-1:0] node_count_ff;
   logic [NODE_W-1:0]   x_ff, y_ff, px_ff, py_ff;
   logic                fresh_ff;
   logic                joined_ff;
   logic                oor_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [NODE_W-1:0]   clr_addr_ff;

   logic                rsp_valid_ff;
   logic [15:0]         rsp_data_ff;
   logic                out_free;
   logic                oor;

   logic                mem_wr_en;
   logic [NODE_W-1:0]   mem_wr_addr;
   logic [NODE_W-1:0]   mem_wr_data;
   logic [NODE_W-1:0]   mem_rd_addr;
   logic [NODE_W-1:0]   mem_rd_data;

   assign cw = ucode_rom(upc_ff);

   // An id is out of range when it is not below node_count. Ids never reach
   // the table depth, so a node_count above it needs no clamping. The test is
   // taken on the original endpoints in the range step and kept in oor_ff,
   // since the walk later moves x_ff and y_ff up the parent chains.
   assign oor = ({1'b0, x_ff} >= node_count_ff) || ({1'b0, y_ff} >= node_count_ff);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (upc_ff == STEP_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Condition select for the conditional jump.
   always_comb begin
      case (cw.cond)
         CND_NEVER:     cond_true = 1'b0;
         CND_ALWAYS:    cond_true = 1'b1;
         CND_REQ_FIRE:  cond_true = req_tvalid;
         CND_NOT_FRESH: cond_true = !fresh_ff;
         CND_CLR_LAST:  cond_true = (clr_addr_ff == LAST_NODE);
         CND_OOR:       cond_true = oor;
         CND_EQ:        cond_true = (px_ff == py_ff);
         CND_LT:        cond_true = (px_ff < py_ff);
         CND_X_ROOT:    cond_true = (x_ff == px_ff);
         CND_Y_ROOT:    cond_true = (y_ff == py_ff);
         CND_OUT_FREE:  cond_true = out_free;
         default:       cond_true = 1'b0;
      endcase
   end

   // Sequencer: jump on a true condition, otherwise hold or step forward.
   always_comb begin
      if (cond_true) begin
         upc_in = cw.target;
      end else if (cw.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   // Parent RAM ports. A link makes the root on the smaller side point to
   // the other side's parent; the clearing pass writes entry i with i.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = clr_addr_ff;
      case (cw.act)
         ACT_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ACT_LINK_X: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = x_ff;
            mem_wr_data = py_ff;
         end
         ACT_LINK_Y: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = y_ff;
            mem_wr_data = px_ff;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (cw.act)
         ACT_LD_PX_RDY: mem_rd_addr = y_ff;
         ACT_STEP_X:    mem_rd_addr = px_ff;
         ACT_STEP_Y:    mem_rd_addr = py_ff;
         default:       mem_rd_addr = x_ff;
      endcase
   end

   rufsf_ram #(
      .WIDTH(NODE_W),
      .DEPTH(NODES)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= STEP_RST_CLEAR;
         node_count_ff <= NODE_COUNT_RESET;
         count_ff      <= '0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         upc_ff <= upc_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (cw.act == ACT_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + NODE_W'(1);
            count_ff    <= '0;
         end else if (cw.act == ACT_LINK_X || cw.act == ACT_LINK_Y) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (cw.act == ACT_LOAD_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers; they need no reset.
   always_ff @(posedge clock) begin
      case (cw.act)
         ACT_LATCH: begin
            if (req_tvalid) begin
               x_ff      <= req_tdata[NODE_W-1:0];
               y_ff      <= req_tdata[2*NODE_W-1:NODE_W];
               fresh_ff  <= req_tuser;
               joined_ff <= 1'b0;
            end
         end
         ACT_RD_X: begin
            oor_ff <= oor;
         end
         ACT_LD_PX_RDY, ACT_LD_PX: begin
            px_ff <= mem_rd_data;
         end
         ACT_LD_PY: begin
            py_ff <= mem_rd_data;
         end
         ACT_STEP_X: begin
            x_ff <= px_ff;
         end
         ACT_STEP_Y: begin
            y_ff <= py_ff;
         end
         ACT_JOIN: begin
            joined_ff <= 1'b1;
         end
         ACT_LOAD_OUT: begin
            if (out_free) begin
               rsp_data_ff <= {2'b00, oor_ff, count_ff, joined_ff};
            end
         end
         default: begin
            joined_ff <= joined_ff;
         end
      endcase
   end

   // A link always attaches a root to a strictly larger parent, which keeps
   // every parent at or above its own index.
   a_link_x_order: assert property (@(posedge clock) disable iff (reset)
      (cw.act == ACT_LINK_X) |-> (px_ff < py_ff))
      else $error("link of x side without smaller parent");

   a_link_y_order: assert property (@(posedge clock) disable iff (reset)
      (cw.act == ACT_LINK_Y) |-> (py_ff < px_ff))
      else $error("link of y side without smaller parent");

   // The forest count moves only on a link or a clearing pass.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (cw.act != ACT_CLEAR && cw.act != ACT_LINK_X && cw.act != ACT_LINK_Y)
      |=> $stable(count_ff))
      else $error("edge count changed outside a link");

   // A new result appears only from the output step.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |-> ($past(upc_ff) == STEP_OUT))
      else $error("result raised outside the output step");

   // No edge is taken while a clearing pass is under way.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (cw.act == ACT_CLEAR) |-> !req_tready)
      else $error("edge accepted during table clearing");

endmodule

[verif/rem_union_find_spanning_forest_core_test.sv]
// Self-checking testbench for the union-find spanning forest core: edge stream in, result stream out.
`timescale 1ns / 100ps

module rem_union_find_spanning_forest_core_test;
   import rufsf_pkg::*;

   // One expected result, held in the order the edges were accepted.
   typedef struct packed {
      logic               joined;
      logic [COUNT_W-1:0] forest_count;
      logic               out_of_range;
   } forest_result_type;

   // The scoreboard keeps a private copy of the parent table, the forest edge
   // count and the node_count register. Every accepted edge is merged into that
   // copy right away, and the resulting expectation waits in a queue until the
   // core returns its result transaction.
   class forest_scoreboard;
      logic [NODE_W-1:0]   parent [NODES];
      logic [COUNT_W-1:0]  forest_edges;
      logic [NCOUNT_W-1:0] node_count;
      forest_result_type   expected_q[$];
      int errors;
      int results_seen;
      int merges;
      int redundant;
      int out_of_range_edges;
      int fresh_graphs;
      int count_writes;

      function new();
         errors             = 0;
         results_seen       = 0;
         merges             = 0;
         redundant          = 0;
         out_of_range_edges = 0;
         fresh_graphs       = 0;
         count_writes       = 0;
         node_count         = NODE_COUNT_RESET;
         clear_forest();
      endfunction

      function void clear_forest();
         for (int i = 0; i < NODES; i++)
            parent[i] = NODE_W'(i);
         forest_edges = '0;
      endfunction

      function void set_node_count(logic [NCOUNT_W-1:0] value);
         node_count = value;
         count_writes++;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Rem's union without splicing. Whichever side has the smaller parent
      // climbs one hop; a root on that side is linked to the other parent.
      // Returns 1 when both ends already sit in one cluster.
      function bit try_merge(logic [NODE_W-1:0] x, logic [NODE_W-1:0] y);
         while (parent[x] != parent[y]) begin
            if (parent[x] < parent[y]) begin
               if (x == parent[x]) begin
                  parent[x] = parent[y];
                  return 1'b0;
               end
               x = parent[x];
            end
            if (parent[x] > parent[y]) begin
               if (y == parent[y]) begin
                  parent[y] = parent[x];
                  return 1'b0;
               end
               y = parent[y];
            end
         end
         return 1'b1;
      endfunction

      // Called for every accepted edge transaction.
      function void note_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b, logic fresh);
         forest_result_type want;
         int limit;
         limit = (int'(node_count) > NODES) ? NODES : int'(node_count);
         if (fresh) begin
            clear_forest();
            fresh_graphs++;
         end
         want.joined       = 1'b0;
         want.out_of_range = 1'b0;
         if (int'(a) >= limit || int'(b) >= limit) begin
            want.out_of_range = 1'b1;
            out_of_range_edges++;
         end else if (try_merge(a, b)) begin
            want.joined = 1'b1;
            redundant++;
         end else begin
            forest_edges = forest_edges + 1'b1;
            merges++;
         end
         want.forest_count = forest_edges;
         expected_q.push_back(want);
      endfunction

      task report(string what, int got, int want);
         $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      // Called for every accepted result transaction.
      task check_result(logic [15:0] word);
         forest_result_type want;
         if (expected_q.size() == 0) begin
            report("result with no edge outstanding", int'(word), -1);
         end else begin
            want = expected_q.pop_front();
            results_seen++;
            if (word[0] !== want.joined)
               report("already_joined", int'(word[0]), int'(want.joined));
            if (word[12:1] !== want.forest_count)
               report("tree_edge_count", int'(word[12:1]), int'(want.forest_count));
            if (word[13] !== want.out_of_range)
               report("out_of_range", int'(word[13]), int'(want.out_of_range));
            if (word[15:14] !== 2'b00)
               report("padding bits", int'(word[15:14]), 0);
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [23:0]         req_tdata;   // [11:0] node_a, [23:12] node_b
   logic                req_tuser;   // [0] new_graph
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [15:0]         rsp_tdata;   // [0] already_joined, [12:1] tree_edge_count,
                                     // [13] out_of_range, [15:14] zero
   logic                csr_wr_en;
   logic [NCOUNT_W-1:0] csr_wr_data;

   forest_scoreboard sb;

   // When set, neither side inserts gaps, so transactions go back to back.
   bit steady;

   // Receiver stall cycles still to come.
   int rsp_hold;

   rem_union_find_spanning_forest_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length for either side: mostly none or a few cycles, now and then a
   // long pause, so that stalls land on every step of the microprogram.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Result side back-pressure. A stall starts right after a ready cycle and
   // holds tready low for the chosen number of cycles.
   initial begin
      rsp_hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
               rsp_hold = pick_gap();
         end
      end
   end

   // Monitor. All three channels are sampled at the rising edge, before the
   // core's own updates of that edge take effect, so every handshake is seen
   // exactly as the core saw it.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            sb.set_node_count(csr_wr_data);
         if (req_tvalid && req_tready)
            sb.note_edge(req_tdata[11:0], req_tdata[23:12], req_tuser);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   // Offers one edge and returns at the edge where it was accepted. tvalid is
   // left high, so a following call with no gap keeps the stream dense.
   task automatic send_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                            input logic fresh);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= fresh;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drops tvalid, waits for every outstanding result, then lets the core
   // settle for a few more cycles. A single edge is in flight at a time and
   // every edge yields a result, so this leaves the core idle.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [NCOUNT_W-1:0] value);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // A phase of random edges under one node_count setting. Most edges lie in
   // range so the forest actually grows and deep chains form; neighbor edges
   // build long parent chains, repeated edges and self loops hit the redundant
   // path, and the remainder is out-of-range noise. A new graph is started now
   // and then, and the table is otherwise carried over from the last phase.
   task automatic run_phase(input int nodes, input int items);
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      logic [NODE_W-1:0] prev_a;
      logic [NODE_W-1:0] prev_b;
      logic              fresh;
      int                span;
      int                r;
      int                hop;
      write_node_count(NCOUNT_W'(nodes));
      span   = (nodes > NODES) ? NODES : nodes;
      steady = ($urandom_range(0, 3) == 0);
      prev_a = '0;
      prev_b = '0;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (span == 0 || r >= 86) begin
            // Noise: at least one id beyond the limit, where the limit leaves room.
            a = NODE_W'($urandom_range(0, NODES - 1));
            b = NODE_W'($urandom_range(0, NODES - 1));
            if (span > 0 && span < NODES) begin
               if ($urandom_range(0, 1))
                  a = NODE_W'($urandom_range(span, NODES - 1));
               else
                  b = NODE_W'($urandom_range(span, NODES - 1));
            end
         end else if (r < 65) begin
            a = NODE_W'($urandom_range(0, span - 1));
            b = NODE_W'($urandom_range(0, span - 1));
         end else if (r < 75) begin
            a   = NODE_W'($urandom_range(0, span - 1));
            hop = int'(a) + $urandom_range(1, 3);
            b   = NODE_W'((hop >= span) ? span - 1 : hop);
         end else if (r < 82) begin
            // The previous edge again, in either direction.
            if ($urandom_range(0, 1)) begin
               a = prev_a;
               b = prev_b;
            end else begin
               a = prev_b;
               b = prev_a;
            end
         end else begin
            a = NODE_W'($urandom_range(0, span - 1));
            b = a;
         end
         fresh = ((i == 0) && ($urandom_range(0, 1) == 1)) || ($urandom_range(0, 59) == 0);
         send_edge(a, b, fresh);
         prev_a = a;
         prev_b = b;
      end
   endtask

   // Node counts for the random phases, the extremes among them, and the
   // number of edges sent under each.
   int phase_nodes [12] = '{64, 2, 8, NODES, 1, 500, 8191, 37, 0, 3000, 16, NODES};
   int phase_items [12] = '{150, 40, 120, 200, 20, 150, 100, 120, 20, 130, 60, 40};

   initial begin
      sb          = new();
      steady      = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed edges under the reset node_count of 4096. The core is still
      // clearing its table after reset, so the first edge waits for tready.
      send_edge(12'd0, 12'd0, 1'b1);          // self loop on a fresh graph
      send_edge(12'd0, 12'd4095, 1'b0);       // lowest and highest ids
      send_edge(12'd4095, 12'd0, 1'b0);       // same edge reversed is redundant
      send_edge(12'd1, 12'd2, 1'b0);
      send_edge(12'd2, 12'd3, 1'b0);
      send_edge(12'd3, 12'd1, 1'b0);          // closes a cycle
      send_edge(12'd4095, 12'd4095, 1'b0);
      send_edge(12'hAAA, 12'h555, 1'b0);      // alternating bit patterns

      // The node count shrinks mid-graph; the table is kept as it is.
      write_node_count(13'd16);
      send_edge(12'd15, 12'd16, 1'b0);        // just past the limit
      send_edge(12'd4095, 12'd3, 1'b0);
      send_edge(12'd3, 12'd15, 1'b0);
      send_edge(12'd0, 12'd15, 1'b0);

      // A single node: only the self loop on node zero is in range.
      write_node_count(13'd1);
      send_edge(12'd0, 12'd0, 1'b0);
      send_edge(12'd0, 12'd1, 1'b0);
      send_edge(12'd1, 12'd0, 1'b1);          // new graph with an out-of-range edge

      // A zero node count puts every id out of range.
      write_node_count(13'd0);
      send_edge(12'd0, 12'd0, 1'b0);

      // A count above the table size is limited to the table size.
      write_node_count(13'd8191);
      send_edge(12'd4095, 12'd0, 1'b0);
      send_edge(12'd4094, 12'd4095, 1'b0);

      write_node_count(NODE_COUNT_RESET);
      send_edge(12'd4095, 12'd4094, 1'b1);

      for (int p = 0; p < 12; p++)
         run_phase(phase_nodes[p], phase_items[p]);

      // Drain: every result back, then a few idle cycles in case anything
      // unexpected still comes out.
      steady = 1'b0;
      wait_quiet();
      repeat (40) @(posedge clock);

      $display("Checked %0d results: %0d merging, %0d redundant, %0d out of range.",
               sb.results_seen, sb.merges, sb.redundant, sb.out_of_range_edges);
      $display("Started %0d new graphs across %0d node_count writes; %0d mismatches.",
               sb.fresh_graphs, sb.count_writes, sb.errors);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, including every table clear.
   initial begin
      #40_000_000;
      $display("Timeout with %0d results outstanding.", sb.pending());
      $display("simulation failed");
      $finish;
   end

endmodule
